### sv/kca_pkg.sv
// ----------------------------------------------------------------------------
// kca_pkg
// Shared types, constants and helpers for the keypad click/autorepeat core.
// ----------------------------------------------------------------------------
package kca_pkg;

  localparam int KEY_COUNT = 12;
  localparam int KEY_BITS  = 16;
  localparam int TIME_BITS = 32;
  localparam int TABLE_LEN = 12;
  localparam int WALK_LEN  = (KEY_COUNT < TABLE_LEN) ? KEY_COUNT : TABLE_LEN;
  localparam int CODE_BITS = 4;
  localparam int DELAY_BITS = 16;
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST_DELAY  = 1'b0,
    CFG_REPEAT_DELAY = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_POLL  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  // Key masks in priority order; key code k is entry k-1.
  localparam logic [31:0] KEY_MASKS [TABLE_LEN] = '{
    32'h0000_0020, 32'h0000_0040, 32'h0000_0080, 32'h0000_0100,
    32'h0000_0200, 32'h0000_0006, 32'h0000_0002, 32'h0000_0008,
    32'h0000_0010, 32'h0000_0400, 32'h0000_0800, 32'h0000_2000
  };

  typedef struct packed {
    opcode_t              opcode;
    logic [KEY_BITS-1:0]  key_word;
    logic [TIME_BITS-1:0] now_ms;
  } kca_item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] event_key;
    logic [CODE_BITS-1:0] clicked_key;
    logic [CODE_BITS-1:0] pressed_key;
  } kca_result_t;

  // One bit per walked key: all of its mask bits are low in the word.
  function automatic logic [WALK_LEN-1:0] keys_down(input logic [KEY_BITS-1:0] word);
    logic [WALK_LEN-1:0] down;
    down = '0;
    for (int i = 0; i < WALK_LEN; i++) begin
      down[i] = ((word & KEY_MASKS[i][KEY_BITS-1:0]) == '0);
    end
    return down;
  endfunction

  // Code of the lowest set bit, 0 when none is set.
  function automatic logic [CODE_BITS-1:0] first_code(input logic [WALK_LEN-1:0] vec);
    logic [CODE_BITS-1:0] code;
    code = '0;
    for (int i = WALK_LEN - 1; i >= 0; i--) begin
      if (vec[i]) begin
        code = CODE_BITS'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

### sv/kca_in_stage.sv
// ----------------------------------------------------------------------------
// kca_in_stage
// Input register: holds one item until the core moves it into the result.
// ----------------------------------------------------------------------------
module kca_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kca_pkg::kca_item_t in_item,
  input  logic               take,
  output logic               item_valid,
  output kca_pkg::kca_item_t item
);
  import kca_pkg::*;

  logic      valid_r, valid_nxt;
  kca_item_t item_r;
  logic      load;

  // The register may refill in the same cycle it hands its item on.
  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### sv/kca_core.sv
// ----------------------------------------------------------------------------
// kca_core
// Key state, delay registers, priority encode and autorepeat timing.
// ----------------------------------------------------------------------------
module kca_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kca_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [kca_pkg::DELAY_BITS-1:0]      cfg_wdata,
  input  logic                                fire,
  input  kca_pkg::kca_item_t                  item,
  output kca_pkg::kca_result_t                res
);
  import kca_pkg::*;

  logic [DELAY_BITS-1:0] first_delay_r, repeat_delay_r;
  logic [KEY_BITS-1:0]   cur_keys_r, cur_keys_nxt;
  logic [KEY_BITS-1:0]   prev_keys_r, prev_keys_nxt;
  logic [CODE_BITS-1:0]  repeat_key_r, repeat_key_nxt;
  logic                  repeating_r, repeating_nxt;
  logic [TIME_BITS-1:0]  last_event_r, last_event_nxt;

  logic [WALK_LEN-1:0]   down_cur, down_prev;
  logic [CODE_BITS-1:0]  clicked, event_key;
  logic                  held;
  logic [TIME_BITS-1:0]  diff, delay;
  logic                  due;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r  <= DELAY_BITS'(500);
      repeat_delay_r <= DELAY_BITS'(175);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FIRST_DELAY:  first_delay_r  <= cfg_wdata;
        CFG_REPEAT_DELAY: repeat_delay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A poll shifts the new word in; a clear looks at the stored words.
  always_comb begin
    if (item.opcode == OP_POLL) begin
      cur_keys_nxt  = item.key_word;
      prev_keys_nxt = cur_keys_r;
    end else begin
      cur_keys_nxt  = cur_keys_r;
      prev_keys_nxt = prev_keys_r;
    end
  end

  assign down_cur  = keys_down(cur_keys_nxt);
  assign down_prev = keys_down(prev_keys_nxt);
  assign clicked   = first_code(down_cur & ~down_prev);

  always_comb begin
    held = 1'b0;
    for (int i = 0; i < WALK_LEN; i++) begin
      if (repeat_key_r == CODE_BITS'(i + 1) && down_cur[i]) begin
        held = 1'b1;
      end
    end
  end

  // Wrap-around elapsed time; a negative difference never fires.
  assign diff  = item.now_ms - last_event_r;
  assign delay = repeating_r ? TIME_BITS'(repeat_delay_r) : TIME_BITS'(first_delay_r);
  assign due   = !diff[TIME_BITS-1] && (diff > delay);

  always_comb begin
    event_key      = '0;
    repeat_key_nxt = repeat_key_r;
    repeating_nxt  = repeating_r;
    last_event_nxt = last_event_r;
    if (item.opcode == OP_CLEAR) begin
      repeat_key_nxt = '0;
    end else if (clicked != '0) begin
      repeat_key_nxt = clicked;
      repeating_nxt  = 1'b0;
      last_event_nxt = item.now_ms;
      event_key      = clicked;
    end else if (held) begin
      if (due) begin
        repeating_nxt  = 1'b1;
        last_event_nxt = item.now_ms;
        event_key      = repeat_key_r;
      end
    end else begin
      repeat_key_nxt = '0;
    end
  end

  assign res.event_key   = event_key;
  assign res.clicked_key = clicked;
  assign res.pressed_key = first_code(down_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_keys_r   <= '0;
      prev_keys_r  <= '0;
      repeat_key_r <= '0;
      repeating_r  <= 1'b0;
      last_event_r <= '0;
    end else if (fire) begin
      cur_keys_r   <= cur_keys_nxt;
      prev_keys_r  <= prev_keys_nxt;
      repeat_key_r <= repeat_key_nxt;
      repeating_r  <= repeating_nxt;
      last_event_r <= last_event_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_forgets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_CLEAR |=> repeat_key_r == '0)
    else $error("repeat key survived a clear");

  a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.event_key != '0 |->
      (res.event_key == res.clicked_key || res.event_key == repeat_key_r))
    else $error("event key is neither the click nor the held key");

  a_event_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.event_key != '0 |=> last_event_r == $past(item.now_ms))
    else $error("event time not recorded");

  a_click_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_POLL && res.clicked_key != '0 |=>
      !repeating_r && repeat_key_r == $past(res.clicked_key))
    else $error("click did not restart the repeat timing");
`endif

endmodule

### sv/kca_out_stage.sv
// ----------------------------------------------------------------------------
// kca_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module kca_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  kca_pkg::kca_result_t res,
  output logic                 fire,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kca_pkg::kca_result_t out_res
);
  import kca_pkg::*;

  logic        valid_r, valid_nxt;
  kca_result_t res_r;
  logic        room;

  assign room      = !valid_r || !out_stall;
  assign fire      = item_valid && room;
  assign valid_nxt = fire || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### sv/keypad_click_autorepeat_core.sv
// ----------------------------------------------------------------------------
// keypad_click_autorepeat_core
// Priority key encoder with click detect and timed autorepeat.
//
//   port group   direction  handshake
//   in_*         input      in_valid / in_stall
//   out_*        output     out_valid / out_stall
//   cfg_*        input      cfg_we, write only
//
// One item per cycle while out_stall is low; a taken item passes first through
// the input register and then through the result register.
// The encode and the elapsed-time compare sit between those two registers.
// A stalled result register holds the input register, which then stalls.
// Reset is synchronous and restores the delays to 500 and 175 ms.
// ----------------------------------------------------------------------------
module keypad_click_autorepeat_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [kca_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [kca_pkg::DELAY_BITS-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_opcode,
  input  logic [kca_pkg::KEY_BITS-1:0]       in_key_word,
  input  logic [kca_pkg::TIME_BITS-1:0]      in_now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [kca_pkg::CODE_BITS-1:0]      out_event_key,
  output logic [kca_pkg::CODE_BITS-1:0]      out_clicked_key,
  output logic [kca_pkg::CODE_BITS-1:0]      out_pressed_key
);
  import kca_pkg::*;

  kca_item_t   in_item, item;
  kca_result_t res, out_res;
  logic        item_valid, fire;

  assign in_item.opcode   = opcode_t'(in_opcode);
  assign in_item.key_word = in_key_word;
  assign in_item.now_ms   = in_now_ms;

  kca_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  kca_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res       (res)
  );

  kca_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .fire       (fire),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_event_key   = out_res.event_key;
  assign out_clicked_key = out_res.clicked_key;
  assign out_pressed_key = out_res.pressed_key;

endmodule
